/* hdl/qpe_pkg.sv */
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, constants and helpers for the quoted-printable encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

    localparam int PENDING_DEPTH = 8;
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int LINE_W        = 7;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam logic [LINE_W-1:0] LIMIT_RESET = 7'd73;
    localparam logic [LINE_W-1:0] LIMIT_MAX   = 7'd120;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_PRT_LO  = 8'd33;
    localparam logic [7:0] CH_PRT_HI  = 8'd126;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOT  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_UNIT,
        OP_NL,
        OP_EOT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
        logic       literal;
        logic       last;
        logic       ovf;
    } t_cmd;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_FLUSH,
        FS_FINAL
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_BRK_EQ,
        BS_BRK_NL,
        BS_LIT,
        BS_EQ,
        BS_HI,
        BS_LO,
        BS_NL
    } t_back_state;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_literal(input logic [7:0] b);
        return (b >= CH_PRT_LO) && (b <= CH_PRT_HI) && (b != CH_EQ);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h41 + {4'd0, v} - 8'd10);
    endfunction

endpackage

/* hdl/qpe_front.sv */
// ----------------------------------------------------------------------------
// qpe_front
// Accepts items, holds pending blanks and issues encode commands.
// ----------------------------------------------------------------------------
module qpe_front import qpe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_in_item,
    output logic     o_cmd_push,
    output t_cmd     o_cmd,
    input  logic     i_cmd_full
);

    t_front_state r_state, n_state;
    t_in_item     r_item;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [PENDING_DEPTH-1:0] r_ws, n_ws;

    logic item_blank;
    logic item_flushes;
    logic flush_lit;
    logic buf_full;
    logic more_pending;
    logic final_push;

    assign full         = (r_state != FS_IDLE);
    assign item_blank   = (r_item.kind == KIND_BYTE) && is_blank(r_item.in_byte);
    assign item_flushes = !item_blank;
    assign flush_lit    = (r_item.kind == KIND_BYTE) && (r_item.in_byte != CH_NL);
    assign buf_full     = (r_cnt == CNT_W'(PENDING_DEPTH));
    assign more_pending = item_flushes && (r_idx < r_cnt);
    assign final_push   = !(item_blank && !buf_full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (push) n_state = FS_FLUSH;
            end
            FS_FLUSH: begin
                if (!more_pending) n_state = FS_FINAL;
            end
            FS_FINAL: begin
                if (!(final_push && i_cmd_full)) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_push = 1'b0;
        o_cmd      = '{op: OP_UNIT, data: CH_SPACE, literal: 1'b0, last: 1'b0, ovf: 1'b0};
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_ws       = r_ws;
        unique case (r_state)
            FS_IDLE: begin
                n_idx = '0;
            end
            FS_FLUSH: begin
                if (more_pending) begin
                    o_cmd_push    = 1'b1;
                    o_cmd.data    = r_ws[r_idx[IDX_W-1:0]] ? CH_TAB : CH_SPACE;
                    o_cmd.literal = flush_lit;
                    if (!i_cmd_full) n_idx = r_idx + CNT_W'(1);
                end
            end
            FS_FINAL: begin
                o_cmd_push = final_push;
                o_cmd.last = 1'b1;
                if (r_item.kind == KIND_EOT) begin
                    o_cmd.op = OP_EOT;
                end else if (item_blank) begin
                    o_cmd.data    = r_ws[0] ? CH_TAB : CH_SPACE;
                    o_cmd.literal = 1'b1;
                    o_cmd.ovf     = 1'b1;
                end else if (r_item.in_byte == CH_NL) begin
                    o_cmd.op = OP_NL;
                end else begin
                    o_cmd.data    = r_item.in_byte;
                    o_cmd.literal = is_literal(r_item.in_byte);
                end
                if (!(final_push && i_cmd_full)) begin
                    if (item_flushes) begin
                        n_cnt = '0;
                    end else if (buf_full) begin
                        for (int i = 0; i < PENDING_DEPTH - 1; i++) n_ws[i] = r_ws[i + 1];
                        n_ws[PENDING_DEPTH-1] = (r_item.in_byte == CH_TAB);
                    end else begin
                        n_ws[r_cnt[IDX_W-1:0]] = (r_item.in_byte == CH_TAB);
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ws <= n_ws;
        if (r_state == FS_IDLE && push) r_item <= i_in_item;
    end

endmodule

/* hdl/qpe_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// qpe_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module qpe_cmd_fifo import qpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW:0]   r_wp;
    logic [FIFO_AW:0]   r_rp;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[FIFO_AW] != r_rp[FIFO_AW]) &&
                     (r_wp[FIFO_AW-1:0] == r_rp[FIFO_AW-1:0]);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp[FIFO_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + (FIFO_AW+1)'(1);
            if (do_pop)  r_rp <= r_rp + (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp[FIFO_AW-1:0]] <= i_cmd;
    end

endmodule

/* hdl/qpe_back.sv */
// ----------------------------------------------------------------------------
// qpe_back
// Carries out commands one output byte per cycle while the output slot is free, tracks line length.
// ----------------------------------------------------------------------------
module qpe_back import qpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LINE_W-1:0] i_cfg_wdata,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output logic              empty,
    input  logic              pop,
    output t_out_item         o_result
);

    t_back_state       r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [LINE_W-1:0] r_line, n_line;
    logic [LINE_W-1:0] r_limit;
    logic              r_brk, n_brk;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              slot_free;
    logic              emit;
    logic [7:0]        e_byte;
    logic              e_last;
    logic [LINE_W-1:0] line_p1;
    logic [LINE_W-1:0] line_p3;

    assign slot_free = !r_out_valid || pop;
    assign empty     = !r_out_valid;
    assign o_result  = r_out;
    assign line_p1   = r_line + LINE_W'(1);
    assign line_p3   = r_line + LINE_W'(3);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        OP_UNIT: n_state = r_brk ? BS_BRK_EQ :
                                           (i_cmd.literal ? BS_LIT : BS_EQ);
                        OP_NL:   n_state = BS_NL;
                        OP_EOT:  n_state = (r_line != '0) ? BS_NL : BS_IDLE;
                        default: n_state = BS_IDLE;
                    endcase
                end
            end
            BS_BRK_EQ: if (slot_free) n_state = BS_BRK_NL;
            BS_BRK_NL: if (slot_free) n_state = r_cmd.literal ? BS_LIT : BS_EQ;
            BS_LIT:    if (slot_free) n_state = BS_IDLE;
            BS_EQ:     if (slot_free) n_state = BS_HI;
            BS_HI:     if (slot_free) n_state = BS_LO;
            BS_LO:     if (slot_free) n_state = BS_IDLE;
            BS_NL:     if (slot_free) n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        n_cmd     = r_cmd;
        n_line    = r_line;
        n_brk     = r_brk;
        emit      = 1'b0;
        e_byte    = CH_EQ;
        e_last    = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (i_cmd.op != OP_UNIT) n_brk = 1'b0;
                end
            end
            BS_BRK_EQ: begin
                emit = 1'b1;
            end
            BS_BRK_NL: begin
                emit   = 1'b1;
                e_byte = CH_NL;
                if (slot_free) begin
                    n_line = '0;
                    n_brk  = 1'b0;
                end
            end
            BS_LIT: begin
                emit   = 1'b1;
                e_byte = r_cmd.data;
                e_last = r_cmd.last;
                if (slot_free) begin
                    n_line = line_p1;
                    n_brk  = (line_p1 > r_limit);
                end
            end
            BS_EQ: begin
                emit = 1'b1;
            end
            BS_HI: begin
                emit   = 1'b1;
                e_byte = hex_digit(r_cmd.data[7:4]);
            end
            BS_LO: begin
                emit   = 1'b1;
                e_byte = hex_digit(r_cmd.data[3:0]);
                e_last = r_cmd.last;
                if (slot_free) begin
                    n_line = line_p3;
                    n_brk  = (line_p3 > r_limit);
                end
            end
            BS_NL: begin
                emit   = 1'b1;
                e_byte = CH_NL;
                e_last = r_cmd.last;
                if (slot_free) n_line = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_line      <= '0;
            r_brk       <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_line  <= n_line;
            r_brk   <= n_brk;
            if (i_cfg_we) r_limit <= (i_cfg_wdata > LIMIT_MAX) ? LIMIT_MAX : i_cfg_wdata;
            if (slot_free) r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (slot_free && emit) begin
            r_out.out_byte    <= e_byte;
            r_out.last_of_run <= e_last;
            r_out.overflow    <= r_cmd.ovf;
        end
    end

endmodule

/* hdl/quoted_printable_encoder_top.sv */
// Flow: an accepted item is registered in the front, its commands pass through the
// command FIFO, and the back loads each one and registers every output byte.
// Throughput: the front takes no new item until it has issued every command for
// the last one, pending blanks included; the back puts out 1 byte per cycle while
// the output slot is free, and loads each command in its idle state.
// Reset: synchronous, active low; clears line length, pending blanks, queues and
// sets the soft break limit to 73.
// ----------------------------------------------------------------------------
// quoted_printable_encoder_top
// Quoted-printable encoder: front classifies items, back emits encoded bytes.
// ----------------------------------------------------------------------------
module quoted_printable_encoder_top import qpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_in_item          i_in_item,
    output logic              empty,
    input  logic              pop,
    output t_out_item         o_result,
    input  logic              i_cfg_we,
    input  logic [LINE_W-1:0] i_cfg_wdata
);

    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    qpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    qpe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_empty (cmd_empty)
    );

    qpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
